FILE: design/stok_pkg.sv
`default_nettype none
package stok_pkg;

  localparam int OFF_W = 32;
  localparam int LC_W = 16;
  localparam int LEN_W = 16;
  localparam int KIND_W = 7;
  localparam int KW_MAX = 11;
  localparam int KW_NUM = 30;
  localparam int WL_W = 4;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t K_EOF = 7'd0;
  localparam kind_t K_STR = 7'd1;
  localparam kind_t K_IDENT = 7'd2;
  localparam kind_t K_KW0 = 7'd3;
  localparam kind_t K_INT = 7'd33;
  localparam kind_t K_UNKNOWN = 7'd64;

  typedef logic [8*KW_MAX-1:0] kw_text_t;

  typedef struct packed {
    kind_t kind;
    logic [LC_W-1:0] start_line;
    logic [LC_W-1:0] start_col;
    logic [OFF_W-1:0] text_offset;
    logic [LEN_W-1:0] text_len;
  } tok_t;

  function automatic kw_text_t kw_str(input int idx);
    kw_text_t s;
    s = '0;
    case (idx)
      0: s[15:0] = "nf";
      1: s[23:0] = "tel";
      2: s[23:0] = "tum";
      3: s[15:0] = "fi";
      4: s[31:0] = "esle";
      5: s[39:0] = "elihw";
      6: s[31:0] = "pool";
      7: s[47:0] = "tcurts";
      8: s[31:0] = "lpmi";
      9: s[31:0] = "mune";
      10: s[39:0] = "hctam";
      11: s[39:0] = "tiart";
      12: s[23:0] = "rof";
      13: s[31:0] = "fles";
      14: s[47:0] = "nruter";
      15: s[31:0] = "eurt";
      16: s[39:0] = "eslaf";
      17: s[23:0] = "dom";
      18: s[23:0] = "esu";
      19: s[23:0] = "bup";
      20: s[47:0] = "nretxe";
      21: s[39:0] = "etarc";
      22: s[47:0] = "efasnu";
      23: s[23:0] = "nyd";
      24: s[87:0] = "selur_orcam";
      25: s[31:0] = "fleS";
      26: s[31:0] = "epyt";
      27: s[39:0] = "tsnoc";
      28: s[15:0] = "sa";
      29: s[7:0] = "_";
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [WL_W-1:0] kw_len(input int idx);
    case (idx)
      0, 3, 28: return 4'd2;
      29: return 4'd1;
      1, 2, 12, 17, 18, 19, 23: return 4'd3;
      4, 6, 8, 9, 13, 15, 25, 26: return 4'd4;
      5, 10, 11, 16, 21, 27: return 4'd5;
      7, 14, 20, 22: return 4'd6;
      24: return 4'd11;
      default: return 4'd0;
    endcase
  endfunction

  function automatic kind_t lead_kind(input logic [7:0] b);
    case (b)
      "/": return 7'd34;
      ":": return 7'd40;
      "-": return 7'd46;
      "=": return 7'd50;
      "!": return 7'd52;
      "<": return 7'd54;
      ">": return 7'd56;
      "&": return 7'd58;
      "|": return 7'd60;
      default: return K_EOF;
    endcase
  endfunction

  function automatic kind_t single_kind(input logic [7:0] b);
    case (b)
      "(": return 7'd35;
      ")": return 7'd36;
      "{": return 7'd37;
      "}": return 7'd38;
      ";": return 7'd41;
      ",": return 7'd42;
      ".": return 7'd43;
      "+": return 7'd44;
      "*": return 7'd47;
      "$": return 7'd61;
      "[": return 7'd62;
      "]": return 7'd63;
      default: return K_UNKNOWN;
    endcase
  endfunction

  function automatic kind_t pair_kind(input logic [7:0] p, input logic [7:0] b);
    case (p)
      ":": return (b == ":") ? 7'd39 : K_EOF;
      "-": return (b == ">") ? 7'd45 : K_EOF;
      "=": return (b == "=") ? 7'd48 : ((b == ">") ? 7'd49 : K_EOF);
      "!": return (b == "=") ? 7'd51 : K_EOF;
      "<": return (b == "=") ? 7'd53 : K_EOF;
      ">": return (b == "=") ? 7'd55 : K_EOF;
      "&": return (b == "&") ? 7'd57 : K_EOF;
      "|": return (b == "|") ? 7'd59 : K_EOF;
      default: return K_EOF;
    endcase
  endfunction

endpackage
`default_nettype wire

FILE: design/source_tokenizer.sv
`default_nettype none
// source tokenizer
// input channel: one source byte per beat on in_src_byte, byte 0 ends the source
// output channel: one token per beat (kind, start line/col, text offset, length)
// out_last marks the final token caused by one input byte
// a token is registered into the output when the byte that ends it is taken
// throughput: one byte per cycle unless the output stalls; a byte that yields
// two tokens holds the input while the second token waits in a spare register
// the end-of-source byte flushes any pending token, emits eof and returns
// all position and scan state to reset
// a stalled receiver holds the output beat; the input takes a new byte as
// long as the output register is free or being drained in the same cycle
// reset: synchronous, active low; clears scan state, position to line 1
// column 1 offset 0, and empties the output registers
// token text is not copied: the consumer reads text by offset and length
module source_tokenizer
  import stok_pkg::*;
(
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_valid,
  output logic            in_ready,
  input  wire [7:0]       in_src_byte,
  output logic            out_valid,
  input  wire             out_ready,
  output logic [KIND_W-1:0] out_kind,
  output logic [LC_W-1:0] out_start_line,
  output logic [LC_W-1:0] out_start_col,
  output logic [OFF_W-1:0] out_text_offset,
  output logic [LEN_W-1:0] out_text_len,
  output logic            out_last
);

  typedef enum logic [2:0] {
    M_IDLE, M_IDENT, M_INT, M_STR, M_ESC, M_OP, M_COMMENT
  } mode_t;

  mode_t mode_r, mode_nxt;
  logic [7:0] pend_r, pend_nxt;
  logic [LC_W-1:0] line_r, line_nxt, col_r, col_nxt, tline_r, tline_nxt, tcol_r, tcol_nxt;
  logic [OFF_W-1:0] off_r, off_nxt, toff_r, toff_nxt;
  logic [LEN_W-1:0] tlen_r, tlen_nxt;
  logic [7:0] wbuf_r [KW_MAX];
  logic wb_we;
  logic [WL_W-1:0] wb_idx;

  logic o_vld_r, o_last_r, s_vld_r;
  tok_t o_tok_r, s_tok_r;

  logic acc;
  logic [1:0] n_tok;
  tok_t t0, t1;
  kind_t kwk;
  kw_text_t word;

  always_comb begin
    for (int i = 0; i < KW_MAX; i++) word[8*i +: 8] = wbuf_r[i];
  end

  stok_kw_match u_kw (.word(word), .len(tlen_r), .kind(kwk));

  assign in_ready = !s_vld_r && (!o_vld_r || out_ready);
  assign acc = in_valid && in_ready;

  function automatic logic is_word(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
           (b >= "0" && b <= "9") || b == "_";
  endfunction

  always_comb begin
    logic [7:0] b;
    logic fresh;
    kind_t pk;
    b = in_src_byte;
    mode_nxt = mode_r;
    pend_nxt = pend_r;
    line_nxt = line_r;
    col_nxt = col_r;
    off_nxt = off_r;
    tline_nxt = tline_r;
    tcol_nxt = tcol_r;
    toff_nxt = toff_r;
    tlen_nxt = tlen_r;
    wb_we = 1'b0;
    wb_idx = tlen_r[WL_W-1:0];
    n_tok = 2'd0;
    t0 = '{kind: K_EOF, start_line: tline_r, start_col: tcol_r,
           text_offset: toff_r, text_len: tlen_r};
    t1 = t0;
    fresh = 1'b0;
    pk = pair_kind(pend_r, b);
    if (b != 8'd0) begin
      if (off_r != '1) off_nxt = off_r + 1'b1;
      if (b == 8'h0a) begin
        if (line_r != '1) line_nxt = line_r + 1'b1;
        col_nxt = LC_W'(1);
      end else if (col_r != '1) begin
        col_nxt = col_r + 1'b1;
      end
    end
    if (b == 8'd0) begin
      unique case (mode_r)
        M_IDENT: begin t0.kind = kwk; n_tok = 2'd1; end
        M_INT: begin t0.kind = K_INT; n_tok = 2'd1; end
        M_STR, M_ESC: begin t0.kind = K_STR; n_tok = 2'd1; end
        M_OP: begin t0.kind = lead_kind(pend_r); n_tok = 2'd1; end
        default: ;
      endcase
      t1 = '{kind: K_EOF, start_line: line_r, start_col: col_r,
             text_offset: off_r, text_len: '0};
      if (n_tok == 2'd0) t0 = t1;
      n_tok = n_tok + 2'd1;
      mode_nxt = M_IDLE;
      pend_nxt = '0;
      line_nxt = LC_W'(1);
      col_nxt = LC_W'(1);
      off_nxt = '0;
      tline_nxt = LC_W'(1);
      tcol_nxt = LC_W'(1);
      toff_nxt = '0;
      tlen_nxt = '0;
    end else begin
      unique case (mode_r)
        M_IDENT: begin
          if (is_word(b)) begin
            wb_we = tlen_r < LEN_W'(KW_MAX);
            if (tlen_r != '1) tlen_nxt = tlen_r + 1'b1;
          end else begin
            t0.kind = kwk; n_tok = 2'd1; fresh = 1'b1;
          end
        end
        M_INT: begin
          if (b >= "0" && b <= "9") begin
            if (tlen_r != '1) tlen_nxt = tlen_r + 1'b1;
          end else begin
            t0.kind = K_INT; n_tok = 2'd1; fresh = 1'b1;
          end
        end
        M_STR: begin
          if (b == "\"") begin
            t0.kind = K_STR; n_tok = 2'd1; mode_nxt = M_IDLE;
          end else begin
            if (tlen_r != '1) tlen_nxt = tlen_r + 1'b1;
            if (b == "\\") mode_nxt = M_ESC;
          end
        end
        M_ESC: begin
          if (tlen_r != '1) tlen_nxt = tlen_r + 1'b1;
          mode_nxt = M_STR;
        end
        M_OP: begin
          pend_nxt = '0;
          if (pend_r == "/" && b == "/") begin
            mode_nxt = M_COMMENT;
          end else if (pk != K_EOF) begin
            tlen_nxt = LEN_W'(2);
            t0.kind = pk; t0.text_len = LEN_W'(2); n_tok = 2'd1;
            mode_nxt = M_IDLE;
          end else begin
            t0.kind = lead_kind(pend_r); n_tok = 2'd1; fresh = 1'b1;
          end
        end
        M_COMMENT: begin
          if (b == 8'h0a) mode_nxt = M_IDLE;
        end
        default: fresh = 1'b1;
      endcase
      if (fresh) begin
        mode_nxt = M_IDLE;
        if (!(b == 8'd32 || (b >= 8'd9 && b <= 8'd13))) begin
          tline_nxt = line_r;
          tcol_nxt = col_r;
          toff_nxt = off_r;
          tlen_nxt = LEN_W'(1);
          if (b == "\"") begin
            tlen_nxt = '0;
            toff_nxt = off_nxt;
            mode_nxt = M_STR;
          end else if (is_word(b) && !(b >= "0" && b <= "9")) begin
            wb_we = 1'b1;
            wb_idx = '0;
            mode_nxt = M_IDENT;
          end else if (b >= "0" && b <= "9") begin
            mode_nxt = M_INT;
          end else if (lead_kind(b) != K_EOF) begin
            pend_nxt = b;
            mode_nxt = M_OP;
          end else begin
            t1 = '{kind: single_kind(b), start_line: line_r, start_col: col_r,
                   text_offset: off_r, text_len: LEN_W'(1)};
            if (n_tok == 2'd0) t0 = t1;
            n_tok = n_tok + 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && wb_we) wbuf_r[wb_idx] <= in_src_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      pend_r <= '0;
      line_r <= LC_W'(1);
      col_r <= LC_W'(1);
      off_r <= '0;
      tline_r <= LC_W'(1);
      tcol_r <= LC_W'(1);
      toff_r <= '0;
      tlen_r <= '0;
      o_vld_r <= 1'b0;
      s_vld_r <= 1'b0;
      o_last_r <= 1'b0;
    end else begin
      if (acc) begin
        mode_r <= mode_nxt;
        pend_r <= pend_nxt;
        line_r <= line_nxt;
        col_r <= col_nxt;
        off_r <= off_nxt;
        tline_r <= tline_nxt;
        tcol_r <= tcol_nxt;
        toff_r <= toff_nxt;
        tlen_r <= tlen_nxt;
      end
      if (acc && n_tok != 2'd0) begin
        o_vld_r <= 1'b1;
        o_tok_r <= t0;
        o_last_r <= (n_tok == 2'd1);
        s_vld_r <= (n_tok == 2'd2);
        s_tok_r <= t1;
      end else if (o_vld_r && out_ready) begin
        o_vld_r <= s_vld_r;
        o_tok_r <= s_tok_r;
        o_last_r <= 1'b1;
        s_vld_r <= 1'b0;
      end
    end
  end

  assign out_valid = o_vld_r;
  assign out_kind = o_tok_r.kind;
  assign out_start_line = o_tok_r.start_line;
  assign out_start_col = o_tok_r.start_col;
  assign out_text_offset = o_tok_r.text_offset;
  assign out_text_len = o_tok_r.text_len;
  assign out_last = o_last_r;

endmodule
`default_nettype wire

FILE: design/stok_kw_match.sv
`default_nettype none
module stok_kw_match
  import stok_pkg::*;
(
  input  wire kw_text_t       word,
  input  wire [LEN_W-1:0]     len,
  output kind_t               kind
);

  kw_text_t mask;

  // only the bytes of the current word take part in the compare
  always_comb begin
    for (int j = 0; j < KW_MAX; j++) begin
      mask[8*j +: 8] = (LEN_W'(j) < len) ? 8'hff : 8'h00;
    end
  end

  always_comb begin
    kind = K_IDENT;
    if (len != '0 && len <= LEN_W'(KW_MAX)) begin
      for (int i = KW_NUM - 1; i >= 0; i--) begin
        if (len[WL_W-1:0] == kw_len(i) && (word & mask) == kw_str(i)) begin
          kind = K_KW0 + KIND_W'(i);
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: sim/tb_source_tokenizer.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_source_tokenizer;
  import stok_pkg::*;

  localparam int MODE_IDLE = 0;
  localparam int MODE_WORD = 1;
  localparam int MODE_NUM = 2;
  localparam int MODE_STR = 3;
  localparam int MODE_ESC = 4;
  localparam int MODE_OP = 5;
  localparam int MODE_CMT = 6;
  localparam longint CYCLE_LIMIT = 400000;
  localparam int ITEM_TARGET = 845;

  typedef struct packed {
    tok_t tok;
    logic last;
  } tok_beat_t;

  class token_scoreboard;
    int mode;
    logic [7:0] op_char;
    logic [LC_W-1:0] line, col, t_line, t_col;
    logic [OFF_W-1:0] offs, t_offs;
    logic [LEN_W-1:0] t_len;
    logic [7:0] word[KW_MAX];
    tok_beat_t pending_toks[$];
    int errors;
    int tokens_seen;

    function void clear();
      mode = MODE_IDLE;
      op_char = 0;
      line = 1; col = 1; offs = 0;
      t_line = 1; t_col = 1; t_offs = 0; t_len = 0;
    endfunction

    function void step_pos(logic [7:0] b);
      if (offs != '1) offs++;
      if (b == 8'h0a) begin
        if (line != '1) line++;
        col = 1;
      end else if (col != '1) col++;
    endfunction

    function void start_tok();
      t_line = line; t_col = col; t_offs = offs; t_len = 0;
    endfunction

    function void grow();
      if (t_len != '1) t_len++;
    endfunction

    function void push_tok(kind_t k);
      tok_beat_t e;
      e.tok.kind = k;
      e.tok.start_line = t_line;
      e.tok.start_col = t_col;
      e.tok.text_offset = t_offs;
      e.tok.text_len = t_len;
      e.last = 0;
      pending_toks.push_back(e);
    endfunction

    function kind_t word_kind();
      string kws[KW_NUM] = '{"fn", "let", "mut", "if", "else", "while", "loop",
        "struct", "impl", "enum", "match", "trait", "for", "self", "return",
        "true", "false", "mod", "use", "pub", "extern", "crate", "unsafe",
        "dyn", {"macro", "_rules"}, "Self", "type", "const", "as", "_"};
      bit hit;
      if (t_len == 0 || t_len > KW_MAX) return K_IDENT;
      for (int i = 0; i < KW_NUM; i++) begin
        if (kws[i].len() == t_len) begin
          hit = 1;
          for (int j = 0; j < t_len; j++) if (kws[i][j] != word[j]) hit = 0;
          if (hit) return kind_t'(K_KW0 + i);
        end
      end
      return K_IDENT;
    endfunction

    function void scan_new(logic [7:0] b);
      bit alpha;
      alpha = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
      mode = MODE_IDLE;
      if (b == 32 || (b >= 9 && b <= 13)) begin
        step_pos(b);
        return;
      end
      start_tok();
      if (b == "\"") begin
        step_pos(b);
        t_offs = offs;
        mode = MODE_STR;
      end else if (alpha) begin
        word[0] = b; t_len = 1; mode = MODE_WORD; step_pos(b);
      end else if (b >= "0" && b <= "9") begin
        t_len = 1; mode = MODE_NUM; step_pos(b);
      end else if (lead_kind(b) != K_EOF) begin
        t_len = 1; op_char = b; mode = MODE_OP; step_pos(b);
      end else begin
        t_len = 1; push_tok(single_kind(b)); step_pos(b);
      end
    endfunction

    function void note_byte(logic [7:0] b);
      int n0;
      kind_t k;
      bit wordc;
      n0 = pending_toks.size();
      wordc = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_"
        || (b >= "0" && b <= "9");
      if (b == 0) begin
        case (mode)
          MODE_WORD: push_tok(word_kind());
          MODE_NUM: push_tok(K_INT);
          MODE_STR, MODE_ESC: push_tok(K_STR);
          MODE_OP: push_tok(lead_kind(op_char));
          default: ;
        endcase
        start_tok();
        push_tok(K_EOF);
        clear();
      end else begin
        case (mode)
          MODE_WORD:
            if (wordc) begin
              if (t_len < KW_MAX) word[t_len] = b;
              grow(); step_pos(b);
            end else begin
              push_tok(word_kind()); scan_new(b);
            end
          MODE_NUM:
            if (b >= "0" && b <= "9") begin
              grow(); step_pos(b);
            end else begin
              push_tok(K_INT); scan_new(b);
            end
          MODE_STR: begin
            if (b == "\"") begin
              push_tok(K_STR); mode = MODE_IDLE;
            end else begin
              grow();
              if (b == "\\") mode = MODE_ESC;
            end
            step_pos(b);
          end
          MODE_ESC: begin
            grow(); mode = MODE_STR; step_pos(b);
          end
          MODE_OP: begin
            k = pair_kind(op_char, b);
            if (op_char == "/" && b == "/") begin
              mode = MODE_CMT; step_pos(b);
            end else if (k != K_EOF) begin
              t_len = 2; push_tok(k); mode = MODE_IDLE; step_pos(b);
            end else begin
              push_tok(lead_kind(op_char)); scan_new(b);
            end
            if (mode != MODE_OP) op_char = 0;
          end
          MODE_CMT: begin
            if (b == 8'h0a) mode = MODE_IDLE;
            step_pos(b);
          end
          default: scan_new(b);
        endcase
      end
      if (pending_toks.size() > n0) pending_toks[pending_toks.size() - 1].last = 1;
    endfunction

    function void check_token(tok_beat_t got);
      tok_beat_t want;
      tokens_seen++;
      if (pending_toks.size() == 0) begin
        $display("%0t: unexpected token kind=%0d line=%0d col=%0d", $time,
          got.tok.kind, got.tok.start_line, got.tok.start_col);
        errors++;
        return;
      end
      want = pending_toks.pop_front();
      if (want.tok.kind != got.tok.kind)
        begin $display("%0t: kind exp %0d got %0d", $time, want.tok.kind, got.tok.kind); errors++; end
      if (want.tok.start_line != got.tok.start_line)
        begin $display("%0t: line exp %0d got %0d", $time, want.tok.start_line,
          got.tok.start_line); errors++; end
      if (want.tok.start_col != got.tok.start_col)
        begin $display("%0t: col exp %0d got %0d", $time, want.tok.start_col,
          got.tok.start_col); errors++; end
      if (want.tok.text_offset != got.tok.text_offset)
        begin $display("%0t: offset exp %0d got %0d", $time, want.tok.text_offset,
          got.tok.text_offset); errors++; end
      if (want.tok.text_len != got.tok.text_len)
        begin $display("%0t: len exp %0d got %0d", $time, want.tok.text_len,
          got.tok.text_len); errors++; end
      if (want.last != got.last)
        begin $display("%0t: last exp %0b got %0b", $time, want.last, got.last); errors++; end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [7:0] in_src_byte = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [KIND_W-1:0] out_kind;
  logic [LC_W-1:0] out_start_line, out_start_col;
  logic [OFF_W-1:0] out_text_offset;
  logic [LEN_W-1:0] out_text_len;
  logic out_last;

  token_scoreboard lexer_sb;
  longint cycle_count = 0;
  int bytes_sent = 0;
  bit no_idle = 0;
  bit hold_out = 0;
  string mr_word;

  source_tokenizer uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_src_byte(in_src_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_kind(out_kind), .out_start_line(out_start_line),
    .out_start_col(out_start_col), .out_text_offset(out_text_offset),
    .out_text_len(out_text_len), .out_last(out_last)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  // sink side: check beats, random stall
  always @(posedge clk) begin
    tok_beat_t got;
    if (rst_n && out_valid && out_ready) begin
      got.tok = {out_kind, out_start_line, out_start_col, out_text_offset, out_text_len};
      got.last = out_last;
      lexer_sb.check_token(got);
    end
    if (!rst_n || hold_out) out_ready <= 0;
    else out_ready <= no_idle || ($urandom_range(99) >= 13);
  end

  task automatic send_byte(input logic [7:0] b);
    while (!no_idle && $urandom_range(99) < 13) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_src_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    lexer_sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] pick_byte();
    string ops = "/():{};,.+-*=!<>&|$[]";
    int r = $urandom_range(99);
    if (r < 30) return 8'("a" + $urandom_range(25));
    if (r < 40) return 8'("0" + $urandom_range(9));
    if (r < 60) return ops[$urandom_range(ops.len() - 1)];
    if (r < 72) return (($urandom_range(3) == 0) ? 8'h0a : " ");
    if (r < 78) return "\"";
    if (r < 82) return "\\";
    if (r < 85) return "_";
    if (r < 88) return 8'd0;
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic send_snippet();
    string frags[12] = '{"fn main() -> i32 { ", "let mut x = 42; ", "if a == b => c ",
      "// note\n", "\"str\\\"q\" ", "", "Self::new ", "a != b && c || d ",
      "x <= y >= z ", "_ as type const ", "return true; ", "while loop for match "};
    frags[5] = {mr_word, "! m "};
    send_text(frags[$urandom_range(11)]);
  endtask

  initial begin
    mr_word = {"macro", "_rules"};
    lexer_sb = new();
    lexer_sb.clear();
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    no_idle = 1;
    // directed: keywords, operators, strings, escapes, comments, edge bytes
    send_text("fn let mut if else while loop struct impl enum match trait for self ");
    send_text({"return true false mod use pub extern crate unsafe dyn ", mr_word, " "});
    send_text({"Self type const as _ ", mr_word, "x abcdefghijklmn 0123\n"});
    send_text("::->=>==!=<=>=&&||/:-=!<>&|$[](){};,.+*");
    send_text("// comment to end\n\"ab\\\"c\" 12a9\t\r\v\f");
    send_byte(8'h80); send_byte(8'hff); send_byte("@"); send_byte(8'h01);
    send_byte("\""); send_byte("x"); send_byte("\\"); send_byte(0);
    send_byte("="); send_byte(0);
    send_byte("a"); send_byte(0);
    send_byte("7"); send_byte(0);
    send_byte(0);
    no_idle = 0;
    fork
      begin
        // back pressure stretch
        repeat (200) @(posedge clk);
        hold_out = 1;
        repeat (150) @(posedge clk);
        hold_out = 0;
      end
      begin
        while (bytes_sent < ITEM_TARGET) begin
          no_idle = (bytes_sent >= 450 && bytes_sent < 600);
          if ($urandom_range(3) != 0) send_snippet();
          else send_byte(pick_byte());
        end
        no_idle = 0;
        send_byte(0);
        in_valid <= 0;
      end
    join
    while (lexer_sb.pending_toks.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("sent %0d source bytes, checked %0d tokens incl. keywords, operators,",
      bytes_sent, lexer_sb.tokens_seen);
    $display("strings, comments and end-of-source flushes under random stalls");
    if (lexer_sb.errors == 0 && lexer_sb.pending_toks.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
`default_nettype wire
